// ===== rtl/cpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Contiguous pool allocator package
// Command and status codes, datapath operations and controller interface types.
// ----------------------------------------------------------------------------
package cpa_pkg;

   localparam logic [1:0] CMD_REQUEST = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ZERO    = 2'd1;
   localparam logic [1:0] ST_NOROOM  = 2'd2;
   localparam logic [1:0] ST_BADREL  = 2'd3;

   // Elements held in one row of the hole map memory.
   localparam int ROW_BITS = 4;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DISPATCH,
      OP_CLR_ROW,
      OP_SCAN_RD,
      OP_DECIDE,
      OP_GRANT_RD,
      OP_GRANT_WR,
      OP_REL_RD,
      OP_REL_UPD,
      OP_OUTPUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic is_req;
      logic is_rel;
      logic is_clr;
      logic zero_len;
      logic has_holes;
      logic rel_out;
      logic fits;
      logic scan_last;
      logic clr_last;
      logic grant_last;
   } sts_type;

endpackage

// ===== rtl/contiguous_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Contiguous pool allocator
// Hands out runs of equal-size pool elements and takes single elements back.
// ----------------------------------------------------------------------------
// The pool keeps a high-water mark and a map of freed holes below it, stored
// four elements to a row in a small RAM. A request (cmd 0) for N elements takes
// the start of the first longest run of holes if that run holds N, otherwise
// room above the mark, otherwise it reports no room. A request that finds holes
// scans one map row per cycle up to the mark, and when holes are granted it
// clears the run's bits in the map, one map row at a time. A release (cmd 1)
// reads the map row of its index and updates it or the mark, unless the index
// is at or above the mark, and a clear (cmd 2) writes every map row back to
// empty. After reset the map is swept once with req_ready low. One result is
// returned per transfer on the input side; a new command may be taken while a
// finished result still waits on the rsp_ side, and it then holds in its last
// cycle until that result is taken. csr_pool_size may be written only while
// the block is idle; values above POOL_DEPTH act as POOL_DEPTH.
module contiguous_pool_allocator_unit #(
   parameter int POOL_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [8:0] req_run_length,
   input  logic [7:0] req_element_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_start_index,
   output logic [8:0] rsp_used_count,
   output logic [8:0] rsp_hole_count,
   input  logic       csr_we,
   input  logic [8:0] csr_wdata
);

   cpa_pkg::cmd_type cmd;
   cpa_pkg::sts_type sts;
   logic [8:0]       pool_size_ff;

   // The pool size register; it resets to a full 256-element pool.
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff <= 9'd256;
      end else if (csr_we) begin
         pool_size_ff <= csr_wdata;
      end
   end

   cpa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   cpa_dpath #(.POOL_DEPTH(POOL_DEPTH)) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_cmd          (req_cmd),
      .req_run_length   (req_run_length),
      .req_element_index(req_element_index),
      .csr_pool_size    (pool_size_ff),
      .rsp_status       (rsp_status),
      .rsp_start_index  (rsp_start_index),
      .rsp_used_count   (rsp_used_count),
      .rsp_hole_count   (rsp_hole_count)
   );

endmodule

// ===== rtl/cpa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cpa_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/cpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Pool allocator controller
// Sequences each command through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module cpa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  cpa_pkg::sts_type sts,
   output cpa_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_DISPATCH, S_CLEAR, S_SCAN, S_SCAN_END, S_DECIDE,
      S_GRANT_RD, S_GRANT_WR, S_REL_RD, S_REL_UPD, S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd.op       = cpa_pkg::OP_NONE;
      case (state_ff)
         S_INIT: begin
            cmd.op = cpa_pkg::OP_CLR_ROW;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = cpa_pkg::OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.op = cpa_pkg::OP_DISPATCH;
            if (sts.is_clr) state_in = S_CLEAR;
            else if (sts.is_req && !sts.zero_len)
               state_in = sts.has_holes ? S_SCAN : S_DECIDE;
            else if (sts.is_rel && !sts.rel_out) state_in = S_REL_RD;
            else state_in = S_FINISH;
         end
         S_CLEAR: begin
            cmd.op = cpa_pkg::OP_CLR_ROW;
            if (sts.clr_last) state_in = S_FINISH;
         end
         S_SCAN: begin
            cmd.op = cpa_pkg::OP_SCAN_RD;
            if (sts.scan_last) state_in = S_SCAN_END;
         end
         S_SCAN_END: state_in = S_DECIDE;
         S_DECIDE: begin
            cmd.op   = cpa_pkg::OP_DECIDE;
            state_in = sts.fits ? S_GRANT_RD : S_FINISH;
         end
         S_GRANT_RD: begin
            cmd.op   = cpa_pkg::OP_GRANT_RD;
            state_in = S_GRANT_WR;
         end
         S_GRANT_WR: begin
            cmd.op   = cpa_pkg::OP_GRANT_WR;
            state_in = sts.grant_last ? S_FINISH : S_GRANT_RD;
         end
         S_REL_RD: begin
            cmd.op   = cpa_pkg::OP_REL_RD;
            state_in = S_REL_UPD;
         end
         S_REL_UPD: begin
            cmd.op   = cpa_pkg::OP_REL_UPD;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = cpa_pkg::OP_OUTPUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/cpa_dpath.sv =====
// ----------------------------------------------------------------------------
// Pool allocator datapath
// Hole map memory, run scanner, pool counters and the result registers.
// ----------------------------------------------------------------------------
module cpa_dpath #(
   parameter int POOL_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  cpa_pkg::cmd_type cmd,
   output cpa_pkg::sts_type sts,
   input  logic [1:0]       req_cmd,
   input  logic [8:0]       req_run_length,
   input  logic [7:0]       req_element_index,
   input  logic [8:0]       csr_pool_size,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_start_index,
   output logic [8:0]       rsp_used_count,
   output logic [8:0]       rsp_hole_count
);

   localparam int RB   = cpa_pkg::ROW_BITS;
   localparam int ROWS = (POOL_DEPTH + RB - 1) / RB;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int EW   = RW + 2;
   localparam int CW   = $clog2(POOL_DEPTH + 1);
   localparam int XW   = (CW > 9) ? CW : 9;
   localparam int WW   = ((EW > XW) ? EW : XW) + 1;

   logic [1:0]    cmd_ff;
   logic [8:0]    n_ff;
   logic [7:0]    idx_ff;
   logic [RW-1:0] ptr_ff, ptr_in;
   logic          pend_ff;
   logic [RW-1:0] pend_row_ff;
   logic [CW-1:0] rl_ff, rl_in, bl_ff, bl_in;
   logic [EW-1:0] rs_ff, rs_in, bs_ff, bs_in;
   logic [CW-1:0] hw_ff, hw_in, alloc_ff, alloc_in, hole_ff, hole_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [EW-1:0] res_start_ff, res_start_in;
   logic [WW-1:0] hi_ff, hi_in;

   logic          wr_en;
   logic [RW-1:0] wr_addr, rd_addr;
   logic [RB-1:0] wr_data, rd_data;

   logic [WW-1:0] hw_w, n_w, idx_w, size_w, bl_w, end_row_w, next_lo_w;
   logic          fits, top_room, rel_bit;

   cpa_ram #(.WIDTH(RB), .DEPTH(ROWS)) u_hole_map (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign hw_w      = WW'(hw_ff);
   assign n_w       = WW'(n_ff);
   assign idx_w     = WW'(idx_ff);
   assign bl_w      = WW'(bl_ff);
   assign size_w    = (WW'(csr_pool_size) > WW'(POOL_DEPTH)) ? WW'(POOL_DEPTH)
                                                            : WW'(csr_pool_size);
   assign end_row_w = (hw_w - WW'(1)) >> 2;
   assign next_lo_w = (WW'(ptr_ff) + WW'(1)) << 2;
   assign fits      = (hole_ff != '0) && (bl_w >= n_w);
   assign top_room  = (size_w > hw_w) && ((size_w - hw_w) >= n_w);
   assign rel_bit   = rd_data[idx_ff[1:0]];

   assign sts.is_req     = (cmd_ff == cpa_pkg::CMD_REQUEST);
   assign sts.is_rel     = (cmd_ff == cpa_pkg::CMD_RELEASE);
   assign sts.is_clr     = (cmd_ff == cpa_pkg::CMD_CLEAR);
   assign sts.zero_len   = (n_ff == '0);
   assign sts.has_holes  = (hole_ff != '0);
   assign sts.rel_out    = (idx_w >= hw_w);
   assign sts.fits       = fits;
   assign sts.scan_last  = (WW'(ptr_ff) == end_row_w);
   assign sts.clr_last   = (ptr_ff == RW'(ROWS - 1));
   assign sts.grant_last = (next_lo_w >= hi_ff);

   // Run tracker over the row read in the previous cycle.
   always_comb begin
      logic [EW-1:0] e;
      e     = '0;
      rl_in = rl_ff;
      rs_in = rs_ff;
      bl_in = bl_ff;
      bs_in = bs_ff;
      if (pend_ff) begin
         for (int j = 0; j < RB; j++) begin
            e = {pend_row_ff, 2'(j)};
            if (rd_data[j]) begin
               if (rl_in == '0) rs_in = e;
               rl_in = rl_in + CW'(1);
               if (rl_in > bl_in) begin
                  bl_in = rl_in;
                  bs_in = rs_in;
               end
            end else begin
               rl_in = '0;
            end
         end
      end
      if (cmd.op == cpa_pkg::OP_LOAD) begin
         rl_in = '0;
         rs_in = '0;
         bl_in = '0;
         bs_in = '0;
      end
   end

   always_comb begin
      logic [WW-1:0] e;
      e             = '0;
      ptr_in        = ptr_ff;
      hw_in         = hw_ff;
      alloc_in      = alloc_ff;
      hole_in       = hole_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      hi_in         = hi_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = '0;
      rd_addr       = ptr_ff;
      case (cmd.op)
         cpa_pkg::OP_LOAD: begin
            ptr_in        = '0;
            res_status_in = cpa_pkg::ST_OK;
            res_start_in  = '0;
         end
         cpa_pkg::OP_DISPATCH: begin
            if (sts.is_req && sts.zero_len) res_status_in = cpa_pkg::ST_ZERO;
            if (sts.is_rel && sts.rel_out) res_status_in = cpa_pkg::ST_BADREL;
         end
         cpa_pkg::OP_CLR_ROW: begin
            wr_en    = 1'b1;
            ptr_in   = ptr_ff + RW'(1);
            hw_in    = '0;
            alloc_in = '0;
            hole_in  = '0;
         end
         cpa_pkg::OP_SCAN_RD: ptr_in = ptr_ff + RW'(1);
         cpa_pkg::OP_DECIDE: begin
            if (fits) begin
               res_start_in = bs_ff;
               ptr_in       = bs_ff[EW-1:2];
               hi_in        = WW'(bs_ff) + n_w;
               hole_in      = hole_ff - CW'(n_w);
               alloc_in     = alloc_ff + CW'(n_w);
            end else if (top_room) begin
               res_start_in = EW'(hw_ff);
               hw_in        = CW'(hw_w + n_w);
               alloc_in     = alloc_ff + CW'(n_w);
            end else begin
               res_status_in = cpa_pkg::ST_NOROOM;
            end
         end
         cpa_pkg::OP_GRANT_WR: begin
            wr_en  = 1'b1;
            ptr_in = ptr_ff + RW'(1);
            for (int j = 0; j < RB; j++) begin
               e = WW'({ptr_ff, 2'(j)});
               wr_data[j] = rd_data[j] &
                            ~((e >= WW'(res_start_ff)) && (e < hi_ff));
            end
         end
         cpa_pkg::OP_REL_RD: rd_addr = idx_w[RW+1:2];
         cpa_pkg::OP_REL_UPD: begin
            wr_addr = idx_w[RW+1:2];
            if (rel_bit) begin
               res_status_in = cpa_pkg::ST_BADREL;
            end else begin
               alloc_in = alloc_ff - CW'(1);
               if (idx_w + WW'(1) == hw_w) begin
                  hw_in = hw_ff - CW'(1);
               end else begin
                  wr_en   = 1'b1;
                  wr_data = rd_data | (RB'(1) << idx_ff[1:0]);
                  hole_in = hole_ff + CW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         pend_ff  <= 1'b0;
         hw_ff    <= '0;
         alloc_ff <= '0;
         hole_ff  <= '0;
      end else begin
         ptr_ff   <= ptr_in;
         pend_ff  <= (cmd.op == cpa_pkg::OP_SCAN_RD);
         hw_ff    <= hw_in;
         alloc_ff <= alloc_in;
         hole_ff  <= hole_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == cpa_pkg::OP_LOAD) begin
         cmd_ff <= req_cmd;
         n_ff   <= req_run_length;
         idx_ff <= req_element_index;
      end
      if (cmd.op == cpa_pkg::OP_OUTPUT) begin
         rsp_status      <= res_status_ff;
         rsp_start_index <= 8'(res_start_ff);
         rsp_used_count  <= 9'(alloc_ff);
         rsp_hole_count  <= 9'(hole_ff);
      end
      pend_row_ff   <= ptr_ff;
      rl_ff         <= rl_in;
      rs_ff         <= rs_in;
      bl_ff         <= bl_in;
      bs_ff         <= bs_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      hi_ff         <= hi_in;
   end

endmodule

// ===== rtl/cpa_checker.sv =====
// ----------------------------------------------------------------------------
// Pool allocator port checker
// Checks handshake timing and result consistency seen at the top level ports.
// ----------------------------------------------------------------------------
module cpa_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_start_index
);

   // A waiting result holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_start_index))
      else $error("result changed while stalled");

   // Failed or trivial commands never report a start element.
   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cpa_pkg::ST_OK |-> rsp_start_index == 8'd0)
      else $error("start index set on a failed command");

   // The hole map sweep after reset keeps the input closed.
   a_init_sweep: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input open during the reset sweep");

   // One command is worked on at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command taken while busy");

endmodule

bind contiguous_pool_allocator_unit cpa_checker u_cpa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_start_index(rsp_start_index)
);

// ===== tb/tb_contiguous_pool_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous pool allocator testbench
// A table of directed transfers first, then random request, release, clear
// and unused-code traffic under several pool sizes. A behavioral model in the
// testbench predicts every response.
// ----------------------------------------------------------------------------
module tb_contiguous_pool_allocator_unit;

   localparam int DEPTH = 256;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 400;
   localparam int FIFO_DEPTH = 1024;

   // The command code that the block ignores.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // A response as it is predicted and as it is seen on the rsp_ ports.
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] start_index;
      logic [8:0] used_count;
      logic [8:0] hole_count;
   } pool_rsp_type;

   // One row of the directed table. The check flag marks rows whose
   // expected response is typed in and compared against the model as well.
   typedef struct packed {
      logic [1:0]   cmd;
      logic [8:0]   run_length;
      logic [7:0]   element_index;
      logic         check;
      pool_rsp_type rsp;
   } pool_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_cmd = cpa_pkg::CMD_REQUEST;
   logic [8:0] req_run_length = '0;
   logic [7:0] req_element_index = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [7:0] rsp_start_index;
   logic [8:0] rsp_used_count;
   logic [8:0] rsp_hole_count;
   logic       csr_we = 1'b0;
   logic [8:0] csr_wdata = '0;

   always #1 clock = ~clock;

   contiguous_pool_allocator_unit #(.POOL_DEPTH(DEPTH)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_run_length(req_run_length), .req_element_index(req_element_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_start_index(rsp_start_index), .rsp_used_count(rsp_used_count),
      .rsp_hole_count(rsp_hole_count), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // Model state of the pool: the hole map, the high-water mark and the two
   // counters, plus the pool size register as last written.
   logic [DEPTH-1:0] model_holes;
   int unsigned model_mark, model_used, model_hole_total;
   logic [8:0]  model_pool_size;

   // Predicted responses in order, written at the input transfer and read
   // at the output transfer.
   pool_rsp_type exp_fifo[FIFO_DEPTH];
   int unsigned exp_wr = 0;
   int unsigned exp_rd = 0;
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void clear_pool_model();
      model_holes = '0;
      model_mark = 0;
      model_used = 0;
      model_hole_total = 0;
   endfunction

   // Works out the response of one command and advances the model state.
   function automatic pool_rsp_type allocate_or_release(input logic [1:0] cmd,
                                                        input logic [8:0] n,
                                                        input logic [7:0] idx);
      pool_rsp_type r;
      int unsigned best_start, best_len, run_start, run_len, size;
      logic granted;
      r = '0;
      r.status = cpa_pkg::ST_OK;
      if (cmd == cpa_pkg::CMD_REQUEST) begin
         granted = 1'b0;
         if (n == 0) begin
            r.status = cpa_pkg::ST_ZERO;
            granted = 1'b1;
         end else if (model_hole_total != 0) begin
            best_start = 0;
            best_len = 0;
            run_start = 0;
            run_len = 0;
            for (int i = 0; i < model_mark && i < DEPTH; i++) begin
               if (model_holes[i]) begin
                  if (run_len == 0) run_start = i;
                  run_len++;
                  if (run_len > best_len) begin
                     best_len = run_len;
                     best_start = run_start;
                  end
               end else begin
                  run_len = 0;
               end
            end
            if (best_len >= n) begin
               for (int i = 0; i < n; i++) model_holes[best_start + i] = 1'b0;
               model_hole_total -= n;
               model_used += n;
               r.start_index = best_start[7:0];
               granted = 1'b1;
            end
         end
         if (!granted) begin
            size = (model_pool_size > DEPTH) ? DEPTH : model_pool_size;
            if (size > model_mark && size - model_mark >= n) begin
               r.start_index = model_mark[7:0];
               model_mark += n;
               model_used += n;
            end else begin
               r.status = cpa_pkg::ST_NOROOM;
            end
         end
      end else if (cmd == cpa_pkg::CMD_RELEASE) begin
         if (idx >= model_mark || model_holes[idx]) begin
            r.status = cpa_pkg::ST_BADREL;
         end else begin
            model_used--;
            if (idx + 1 == model_mark) begin
               model_mark--;
            end else begin
               model_holes[idx] = 1'b1;
               model_hole_total++;
            end
         end
      end else if (cmd == cpa_pkg::CMD_CLEAR) begin
         clear_pool_model();
      end
      r.used_count = model_used[8:0];
      r.hole_count = model_hole_total[8:0];
      return r;
   endfunction

   // Drives one transfer from a falling edge and holds it until a rising
   // edge sees ready. Valid stays high afterwards; the next transfer or an
   // idle period takes it over at the following falling edge.
   task automatic send_cmd(input logic [1:0] cmd, input logic [8:0] n,
                           input logic [7:0] idx);
      req_cmd <= cmd;
      req_run_length <= n;
      req_element_index <= idx;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      exp_fifo[exp_wr % FIFO_DEPTH] = allocate_or_release(cmd, n, idx);
      exp_wr++;
      @(negedge clock);
   endtask

   task automatic idle_gap(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Waits for every response, then lets the block settle before a write.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (exp_wr != exp_rd) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_pool_size(input logic [8:0] value);
      drain_and_settle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      model_pool_size = value;
   endtask

   // Random command mix: mostly requests and releases of elements below the mark.
   task automatic send_random_cmd();
      int unsigned pick;
      logic [8:0] n;
      logic [7:0] idx;
      pick = $urandom_range(99);
      if (pick < 45) begin
         n = ($urandom_range(15) == 0) ? 9'($urandom_range(511))
                                       : 9'($urandom_range(12));
         send_cmd(cpa_pkg::CMD_REQUEST, n, 8'($urandom));
      end else if (pick < 93) begin
         if (model_mark != 0 && $urandom_range(9) != 0)
            idx = 8'($urandom_range(model_mark - 1));
         else
            idx = 8'($urandom);
         send_cmd(cpa_pkg::CMD_RELEASE, 9'($urandom), idx);
      end else if (pick < 96) begin
         send_cmd(cpa_pkg::CMD_CLEAR, 9'($urandom), 8'($urandom));
      end else begin
         send_cmd(CMD_UNUSED, 9'($urandom), 8'($urandom));
      end
   endtask

   // Receiver: stalls in its own pattern.
   initial begin
      int unsigned phase;
      phase = 0;
      forever begin
         @(negedge clock);
         phase++;
         if (phase % 200 < 60) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(3) != 0);
      end
   end

   // Checks every accepted response against the prediction.
   always @(posedge clock) begin
      pool_rsp_type seen, want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_status, rsp_start_index, rsp_used_count, rsp_hole_count};
         if (exp_wr == exp_rd) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = exp_fifo[exp_rd % FIFO_DEPTH];
            exp_rd++;
            if (seen.status != want.status)
               report_mismatch("status", seen.status, want.status);
            if (seen.start_index != want.start_index)
               report_mismatch("start_index", seen.start_index, want.start_index);
            if (seen.used_count != want.used_count)
               report_mismatch("used_count", seen.used_count, want.used_count);
            if (seen.hole_count != want.hole_count)
               report_mismatch("hole_count", seen.hole_count, want.hole_count);
         end
      end
   end

   // Watchdog: counts cycles with no transfer on either side. The reset
   // sweep of the hole map is well inside the limit.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Directed table: expected values are typed in only where obvious.
   pool_row_type directed_rows[] = '{
      '{cpa_pkg::CMD_REQUEST, 9'd0,   8'd0,   1'b1,
        '{cpa_pkg::ST_ZERO,   8'd0, 9'd0,   9'd0}},
      '{cpa_pkg::CMD_RELEASE, 9'd0,   8'd0,   1'b1,
        '{cpa_pkg::ST_BADREL, 8'd0, 9'd0,   9'd0}},
      '{cpa_pkg::CMD_REQUEST, 9'd511, 8'd0,   1'b1,
        '{cpa_pkg::ST_NOROOM, 8'd0, 9'd0,   9'd0}},
      '{cpa_pkg::CMD_REQUEST, 9'd257, 8'd255, 1'b1,
        '{cpa_pkg::ST_NOROOM, 8'd0, 9'd0,   9'd0}},
      '{cpa_pkg::CMD_REQUEST, 9'd256, 8'd0,   1'b1,
        '{cpa_pkg::ST_OK,     8'd0, 9'd256, 9'd0}},
      '{cpa_pkg::CMD_REQUEST, 9'd1,   8'd0,   1'b1,
        '{cpa_pkg::ST_NOROOM, 8'd0, 9'd256, 9'd0}},
      '{cpa_pkg::CMD_RELEASE, 9'd0,   8'd255, 1'b1,
        '{cpa_pkg::ST_OK,     8'd0, 9'd255, 9'd0}},
      '{cpa_pkg::CMD_RELEASE, 9'd0,   8'd255, 1'b1,
        '{cpa_pkg::ST_BADREL, 8'd0, 9'd255, 9'd0}},
      '{cpa_pkg::CMD_RELEASE, 9'd0,   8'd0,   1'b1,
        '{cpa_pkg::ST_OK,     8'd0, 9'd254, 9'd1}},
      '{cpa_pkg::CMD_RELEASE, 9'd0,   8'd0,   1'b1,
        '{cpa_pkg::ST_BADREL, 8'd0, 9'd254, 9'd1}},
      '{cpa_pkg::CMD_RELEASE, 9'd0,   8'd1,   1'b0, '0},
      '{cpa_pkg::CMD_RELEASE, 9'd0,   8'd5,   1'b0, '0},
      '{cpa_pkg::CMD_RELEASE, 9'd0,   8'd6,   1'b0, '0},
      '{cpa_pkg::CMD_RELEASE, 9'd0,   8'd7,   1'b0, '0},
      '{cpa_pkg::CMD_REQUEST, 9'd3,   8'd0,   1'b0, '0},
      '{cpa_pkg::CMD_REQUEST, 9'd2,   8'd0,   1'b0, '0},
      '{cpa_pkg::CMD_REQUEST, 9'd3,   8'd0,   1'b0, '0},
      '{cpa_pkg::CMD_REQUEST, 9'd1,   8'd0,   1'b0, '0},
      '{CMD_UNUSED,           9'd511, 8'd170, 1'b1,
        '{cpa_pkg::ST_OK,     8'd0, 9'd256, 9'd0}},
      '{cpa_pkg::CMD_CLEAR,   9'd0,   8'd0,   1'b1,
        '{cpa_pkg::ST_OK,     8'd0, 9'd0,   9'd0}},
      '{cpa_pkg::CMD_REQUEST, 9'd100, 8'd85,  1'b1,
        '{cpa_pkg::ST_OK,     8'd0, 9'd100, 9'd0}}
   };

   // The sizes visited by the random phases, the extremes among them.
   logic [8:0] pool_sizes[] = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd40, 9'd257, 9'd8, 9'd200};

   initial begin
      pool_rsp_type got;
      int unsigned burst;
      clear_pool_model();
      model_pool_size = 9'd256;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         got = allocate_or_release_peek(directed_rows[i]);
         if (directed_rows[i].check && got != directed_rows[i].rsp)
            report_mismatch("table row", got, directed_rows[i].rsp);
         send_cmd(directed_rows[i].cmd, directed_rows[i].run_length,
                  directed_rows[i].element_index);
      end

      // Pool size below the mark: holes can be granted, nothing above it.
      write_pool_size(9'd50);
      send_cmd(cpa_pkg::CMD_RELEASE, 9'd0, 8'd10);
      send_cmd(cpa_pkg::CMD_REQUEST, 9'd1, 8'd0);
      send_cmd(cpa_pkg::CMD_REQUEST, 9'd1, 8'd0);

      foreach (pool_sizes[p]) begin
         write_pool_size(pool_sizes[p]);
         for (int k = 0; k < 110; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && k < 110; b++, k++) send_random_cmd();
            if ($urandom_range(2) != 0) idle_gap($urandom_range(1, 30));
         end
      end

      drain_and_settle();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // The model's answer for a row, without touching the model state.
   function automatic pool_rsp_type allocate_or_release_peek(input pool_row_type row);
      logic [DEPTH-1:0] holes_save;
      int unsigned mark_save, used_save, hole_save;
      pool_rsp_type r;
      holes_save = model_holes;
      mark_save = model_mark;
      used_save = model_used;
      hole_save = model_hole_total;
      r = allocate_or_release(row.cmd, row.run_length, row.element_index);
      model_holes = holes_save;
      model_mark = mark_save;
      model_used = used_save;
      model_hole_total = hole_save;
      return r;
   endfunction

endmodule
